>>> hdl/tsp_pkg.sv
// shared types and codes for the tlv stream parser
`default_nettype none

package tsp_pkg;

  // default number of nesting levels the parser tracks
  localparam int DEFAULT_MAX_DEPTH = 4;

  // field widths
  localparam int ID_W  = 16;
  localparam int LEN_W = 24;

  // record kinds
  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_VALUE  = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  // error codes
  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_TRUNCATED = 2'd1;
  localparam logic [1:0] ERR_OVERRUN   = 2'd2;
  localparam logic [1:0] ERR_TOO_DEEP  = 2'd3;

  // element types that open a nested level
  localparam logic [1:0] ELEM_OBJ_INST  = 2'd0;
  localparam logic [1:0] ELEM_MULTI_RES = 2'd2;

  // one result record
  typedef struct packed {
    logic [1:0]       kind;
    logic [1:0]       etype;
    logic [ID_W-1:0]  id;
    logic [LEN_W-1:0] vlen;
    logic [1:0]       depth;
    logic [7:0]       data;
    logic             last;
    logic [1:0]       err;
  } record_t;

  // occupancy of the output buffer
  typedef struct packed {
    logic out_valid;
    logic skid_valid;
  } buf_status_t;

endpackage

`default_nettype wire

>>> hdl/tsp_parse_core.sv
// parser state and per-byte next-state and record logic
`default_nettype none

module tsp_parse_core #(
  parameter int MAX_DEPTH = tsp_pkg::DEFAULT_MAX_DEPTH
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            fire,
  input  wire logic [7:0]      payload_byte,
  input  wire logic            end_of_payload,
  output logic                 res_valid,
  output tsp_pkg::record_t     res
);
  import tsp_pkg::*;

  localparam int IW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam logic [IW:0] DEPTH_LIM = (IW+1)'(MAX_DEPTH - 1);

  // parse phases
  localparam logic [1:0] PH_TYPE  = 2'd0;
  localparam logic [1:0] PH_ID    = 2'd1;
  localparam logic [1:0] PH_LEN   = 2'd2;
  localparam logic [1:0] PH_VALUE = 2'd3;

  // control state
  logic [1:0]       phase, phase_next;
  logic [IW-1:0]    open_lv, open_lv_next;
  logic             latched, latched_next;
  // header and count registers
  logic [7:0]       tbits, tbits_next;
  logic [1:0]       fbl, fbl_next;
  logic [ID_W-1:0]  id_acc, id_next;
  logic [LEN_W-1:0] len_acc, len_next;
  logic [LEN_W-1:0] vbl, vbl_next;
  logic [LEN_W-1:0] lv [MAX_DEPTH];
  logic [LEN_W-1:0] lv_next [MAX_DEPTH];

  // working signals
  logic [IW-1:0]    open_idx, open_mid, open_pop;
  logic [IW+1:0]    open_ext;
  logic [LEN_W-1:0] inner_pre, inner_post, vdec;
  logic [1:0]       fdec, err;
  logic             hdr_done, emit, is_cont;
  record_t          rec;

  assign open_idx = open_lv - IW'(1);
  assign open_ext = {2'b00, open_lv};
  assign is_cont  = (tbits[7:6] == ELEM_OBJ_INST) || (tbits[7:6] == ELEM_MULTI_RES);

  // next state and record for one byte
  always_comb begin
    phase_next   = phase;
    open_lv_next = open_lv;
    latched_next = latched;
    tbits_next   = tbits;
    fbl_next     = fbl;
    id_next      = id_acc;
    len_next     = len_acc;
    vbl_next     = vbl;
    lv_next      = lv;
    open_mid     = open_lv;
    open_pop     = '0;
    err          = ERR_NONE;
    hdr_done     = 1'b0;
    emit         = 1'b0;
    fdec         = fbl - {1'b0, (fbl != 2'd0)};
    vdec         = vbl - LEN_W'(vbl != '0);
    inner_pre    = (open_lv != '0) ? lv[open_idx] : '0;
    inner_post   = inner_pre - LEN_W'(inner_pre != '0);
    rec          = '0;
    rec.kind     = KIND_HEADER;

    if (latched) begin
      // drop bytes until end of payload
    end else if ((phase == PH_ID || phase == PH_LEN) && open_lv != '0 && inner_pre == '0) begin
      err = ERR_OVERRUN;
    end else begin
      // every consumed byte counts against all open levels
      for (int i = 0; i < MAX_DEPTH; i++) begin
        if (i < int'(open_lv) && lv[i] != '0) begin
          lv_next[i] = lv[i] - LEN_W'(1);
        end
      end

      unique case (phase)
        PH_TYPE: begin
          tbits_next = payload_byte;
          id_next    = '0;
          len_next   = '0;
          fbl_next   = payload_byte[5] ? 2'd2 : 2'd1;
          phase_next = PH_ID;
        end
        PH_ID: begin
          id_next  = {id_acc[7:0], payload_byte};
          fbl_next = fdec;
          if (fdec == 2'd0) begin
            if (tbits[4:3] != 2'd0) begin
              fbl_next   = tbits[4:3];
              phase_next = PH_LEN;
            end else begin
              len_next = {{(LEN_W-3){1'b0}}, tbits[2:0]};
              hdr_done = 1'b1;
            end
          end
        end
        PH_LEN: begin
          len_next = {len_acc[LEN_W-9:0], payload_byte};
          fbl_next = fdec;
          if (fdec == 2'd0) begin
            hdr_done = 1'b1;
          end
        end
        default: begin
          vbl_next = vdec;
          emit     = 1'b1;
          rec.kind = KIND_VALUE;
          rec.data = payload_byte;
          rec.last = (vdec == '0);
          if (vdec == '0) begin
            phase_next = PH_TYPE;
          end
        end
      endcase

      // completed header: check against the enclosing level
      if (hdr_done) begin
        if (open_lv != '0 && len_next > inner_post) begin
          err = ERR_OVERRUN;
        end else if (is_cont) begin
          if ({1'b0, open_lv} >= DEPTH_LIM) begin
            err = ERR_TOO_DEEP;
          end else begin
            emit             = 1'b1;
            lv_next[open_lv] = len_next;
            open_mid         = open_lv + IW'(1);
            phase_next       = PH_TYPE;
          end
        end else begin
          emit       = 1'b1;
          vbl_next   = len_next;
          phase_next = (len_next == '0) ? PH_TYPE : PH_VALUE;
        end
      end

      // close every exhausted level between elements
      open_lv_next = open_mid;
      if (err == ERR_NONE && phase_next == PH_TYPE) begin
        for (int i = 0; i < MAX_DEPTH; i++) begin
          if (i < int'(open_mid) && lv_next[i] != '0) begin
            open_pop = IW'(i + 1);
          end
        end
        open_lv_next = open_pop;
      end

      // end of payload inside an element or an open level
      if (err == ERR_NONE && end_of_payload &&
          (phase_next != PH_TYPE || open_lv_next != '0)) begin
        err = ERR_TRUNCATED;
      end
    end

    // header fields shared by header and value records
    rec.etype = tbits[7:6];
    rec.id    = id_next;
    rec.vlen  = len_next;
    rec.depth = open_ext[1:0];

    if (err != ERR_NONE) begin
      emit         = 1'b1;
      rec          = '0;
      rec.kind     = KIND_ERROR;
      rec.err      = err;
      latched_next = 1'b1;
    end

    // back to the top level after the last payload byte
    if (end_of_payload) begin
      phase_next   = PH_TYPE;
      open_lv_next = '0;
      latched_next = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_TYPE;
      open_lv <= '0;
      latched <= 1'b0;
    end else if (fire) begin
      phase   <= phase_next;
      open_lv <= open_lv_next;
      latched <= latched_next;
    end
  end

  // header and count registers
  always_ff @(posedge clk) begin
    if (fire) begin
      tbits   <= tbits_next;
      fbl     <= fbl_next;
      id_acc  <= id_next;
      len_acc <= len_next;
      vbl     <= vbl_next;
      lv      <= lv_next;
    end
  end

  assign res_valid = fire && emit;
  assign res       = rec;

endmodule

`default_nettype wire

>>> hdl/tsp_out_buf.sv
// two-entry output register with skid stage
`default_nettype none

module tsp_out_buf (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire tsp_pkg::record_t  push_rec,
  output logic                   space,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output tsp_pkg::record_t       out_rec,
  output tsp_pkg::buf_status_t   status
);
  import tsp_pkg::*;

  logic    ov, sv;
  record_t main_rec, skid_rec;

  // valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
      sv <= 1'b0;
    end else if (out_ready || !ov) begin
      ov <= sv || push;
      sv <= 1'b0;
    end else if (push) begin
      sv <= 1'b1;
    end
  end

  // record storage
  always_ff @(posedge clk) begin
    if (out_ready || !ov) begin
      if (sv) begin
        main_rec <= skid_rec;
      end else if (push) begin
        main_rec <= push_rec;
      end
    end else if (push) begin
      skid_rec <= push_rec;
    end
  end

  assign space             = !sv;
  assign out_valid         = ov;
  assign out_rec           = main_rec;
  assign status.out_valid  = ov;
  assign status.skid_valid = sv;

endmodule

`default_nettype wire

>>> hdl/tlv_stream_parser.sv
// top level of the streaming tlv parser
//
// Input channel: one payload byte per request on payload_byte, with
// end_of_payload high on the last byte of a payload. Output channel: at most
// one record per input byte: an element header, a value byte, or an error.
// A record is registered in the output register, or in the skid stage if a
// record waits there. Throughput: one byte per cycle while in_ready is high;
// each byte updates the parser registers in a single combinational pass
// between the input handshake and the output register.
// Output stall: an output register plus a one-entry skid stage lets the
// parser take a byte while a record waits; in_ready drops only when the
// skid stage is full, and no record is lost or repeated.
// After an error record the rest of the payload is dropped; the byte with
// end_of_payload returns the parser to the top level with all levels closed.
// Reset (rst, synchronous) returns the parser to the top level, clears the
// error state and empties the output buffer; no clearing pass is needed.
// MAX_DEPTH sets how many nesting levels are tracked.
`default_nettype none

module tlv_stream_parser #(
  parameter int MAX_DEPTH = tsp_pkg::DEFAULT_MAX_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  payload_byte,
  input  wire logic        end_of_payload,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       record_kind,
  output logic [1:0]       element_type,
  output logic [15:0]      element_id,
  output logic [23:0]      value_length,
  output logic [1:0]       nest_depth,
  output logic [7:0]       value_data,
  output logic             last_of_value,
  output logic [1:0]       error_code
);
  import tsp_pkg::*;

  logic        fire, res_valid, space;
  record_t     res, out_rec;
  buf_status_t status;

  assign in_ready = space;
  assign fire     = in_valid && space;

  // parser
  tsp_parse_core #(
    .MAX_DEPTH(MAX_DEPTH)
  ) u_core (
    .clk            (clk),
    .rst            (rst),
    .fire           (fire),
    .payload_byte   (payload_byte),
    .end_of_payload (end_of_payload),
    .res_valid      (res_valid),
    .res            (res)
  );

  // output buffer
  tsp_out_buf u_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_rec  (res),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_rec   (out_rec),
    .status    (status)
  );

  // record fields
  assign record_kind   = out_rec.kind;
  assign element_type  = out_rec.etype;
  assign element_id    = out_rec.id;
  assign value_length  = out_rec.vlen;
  assign nest_depth    = out_rec.depth;
  assign value_data    = out_rec.data;
  assign last_of_value = out_rec.last;
  assign error_code    = out_rec.err;

  // skid stage only fills behind a waiting record
  a_skid_behind_main: assert property (@(posedge clk) disable iff (rst)
    status.skid_valid |-> status.out_valid)
    else $error("skid stage holds a record while output register is empty");

  // error records always carry a code, others never
  a_err_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((record_kind == KIND_ERROR) == (error_code != ERR_NONE)))
    else $error("error code does not match record kind");

  // last marker only on value records
  a_last_value: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last_of_value) |-> (record_kind == KIND_VALUE))
    else $error("last marker on a non-value record");

  // a full buffer that is stalled keeps input blocked
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (status.skid_valid && !out_ready) |=> !in_ready)
    else $error("input accepted while output buffer is full");

endmodule

`default_nettype wire
